// ----- src/srps_pkg.sv -----
package srps_pkg;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_START = 2'd1,
		OP_REPLY = 2'd2,
		OP_TICK  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_REQ  = 2'd0,
		KIND_BYTE = 2'd1,
		KIND_DONE = 2'd2
	} kind_t;

	localparam logic [15:0] TIMEOUT_RESET = 16'd550;
	localparam logic [7:0]  FAIL_BYTE     = 8'hff;
	localparam logic [15:0] TICK_MAX      = 16'hffff;

	// Work handed from the controller to the result emitter for one item.
	typedef struct packed {
		logic [3:0]  nbytes;
		logic [71:0] bytes;
		logic [10:0] base;
		logic        fin_done;
		logic [7:0]  requester;
		logic [7:0]  addr;
		logic [3:0]  len;
		logic [10:0] total;
	} job_t;

endpackage

// ----- src/srps_id_mem.sv -----
module srps_id_mem #(
	parameter int DEPTH = 128,
	parameter int IDX_W = 7
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  logic [7:0]       wdata,
	input  logic             re,
	input  logic [IDX_W-1:0] raddr,
	output logic [7:0]       rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- src/srps_ctrl.sv -----
module srps_ctrl #(
	parameter int MAX_IDS    = 128,
	parameter int MAX_LENGTH = 8,
	parameter int IDX_W      = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_accept,
	input  logic [1:0]       op,
	input  logic [7:0]       target_id,
	input  logic [7:0]       read_addr,
	input  logic [3:0]       read_length,
	input  logic [7:0]       reply_error,
	input  logic [7:0]       reply_count,
	input  logic [63:0]      reply_data,
	input  logic             cfg_we,
	input  logic [15:0]      cfg_data,
	output logic             mem_we,
	output logic [IDX_W-1:0] mem_waddr,
	output logic [7:0]       mem_wdata,
	output logic             mem_re,
	output logic [IDX_W-1:0] mem_raddr,
	output logic             job_load,
	output srps_pkg::job_t   job
);

	import srps_pkg::*;

	logic [15:0] timeout_q;
	logic [7:0]  cnt_q, cnt_d;
	logic [7:0]  cur_q, cur_d;
	logic        busy_q, busy_d;
	logic [7:0]  addr_q, addr_d;
	logic [3:0]  len_q, len_d;
	logic [7:0]  req_q, req_d;
	logic [15:0] elapsed_q, elapsed_d;

	logic [3:0]  lenp1;
	logic [3:0]  len_sat;
	logic [7:0]  nxt;
	logic [11:0] base_prod;
	logic [11:0] total_prod;
	logic [15:0] elapsed_inc;
	logic        advance;

	assign lenp1       = len_q + 4'd1;
	assign len_sat     = (read_length > 4'(MAX_LENGTH)) ? 4'(MAX_LENGTH) : read_length;
	assign nxt         = cur_q + 8'd1;
	assign base_prod   = 12'(cur_q) * 12'(lenp1);
	assign total_prod  = 12'(cnt_q) * 12'(lenp1);
	assign elapsed_inc = (elapsed_q == TICK_MAX) ? elapsed_q : elapsed_q + 16'd1;

	assign mem_waddr = cnt_q[IDX_W-1:0];
	assign mem_wdata = target_id;

	always_comb begin
		cnt_d     = cnt_q;
		cur_d     = cur_q;
		busy_d    = busy_q;
		addr_d    = addr_q;
		len_d     = len_q;
		req_d     = req_q;
		elapsed_d = elapsed_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		job_load  = 1'b0;
		advance   = 1'b0;

		job.nbytes    = 4'd0;
		job.bytes     = {reply_data, reply_error};
		job.base      = 11'(base_prod);
		job.fin_done  = 1'b0;
		job.requester = req_q;
		job.addr      = addr_q;
		job.len       = len_q;
		job.total     = 11'(total_prod);

		if (in_accept) begin
			case (op_t'(op))
				OP_ADD: begin
					if (!busy_q && cnt_q < 8'(MAX_IDS)) begin
						mem_we = 1'b1;
						cnt_d  = cnt_q + 8'd1;
					end
				end
				OP_START: begin
					if (!busy_q && cnt_q != 8'd0) begin
						req_d     = target_id;
						addr_d    = read_addr;
						len_d     = len_sat;
						cur_d     = 8'd0;
						busy_d    = 1'b1;
						elapsed_d = 16'd0;
						mem_re    = 1'b1;
						mem_raddr = '0;
						job_load  = 1'b1;
						job.addr  = read_addr;
						job.len   = len_sat;
					end
				end
				OP_REPLY: begin
					if (busy_q && reply_count == 8'(len_q)) begin
						job.nbytes = lenp1;
						advance    = 1'b1;
					end
				end
				OP_TICK: begin
					if (busy_q) begin
						elapsed_d = elapsed_inc;
						if (elapsed_inc > timeout_q) begin
							job.nbytes = 4'd1;
							job.bytes  = {64'd0, FAIL_BYTE};
							advance    = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase

			if (advance) begin
				job_load = 1'b1;
				cur_d    = nxt;
				if (nxt >= cnt_q) begin
					busy_d       = 1'b0;
					cnt_d        = 8'd0;
					job.fin_done = 1'b1;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = nxt[IDX_W-1:0];
					elapsed_d = 16'd0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
			cnt_q     <= 8'd0;
			cur_q     <= 8'd0;
			busy_q    <= 1'b0;
			addr_q    <= 8'd0;
			len_q     <= 4'd0;
			req_q     <= 8'd0;
			elapsed_q <= 16'd0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_data;
			end
			cnt_q     <= cnt_d;
			cur_q     <= cur_d;
			busy_q    <= busy_d;
			addr_q    <= addr_d;
			len_q     <= len_d;
			req_q     <= req_d;
			elapsed_q <= elapsed_d;
		end
	end

	// While a group is running, the poll position always names a listed id.
	a_busy_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q != 8'd0 && cur_q < cnt_q))
		else $error("poll position outside the id list while busy");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 8'(MAX_IDS))
		else $error("id count exceeds list depth");

endmodule

// ----- src/srps_emit.sv -----
module srps_emit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_load,
	input  srps_pkg::job_t job,
	input  logic [7:0]     mem_rdata,
	output logic           busy,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [1:0]     kind,
	output logic [7:0]     bus_id,
	output logic [7:0]     req_addr,
	output logic [3:0]     req_length,
	output logic [10:0]    slot,
	output logic [7:0]     value,
	output logic [10:0]    total,
	output logic           last
);

	import srps_pkg::*;

	logic        active_q;
	logic [3:0]  rem_q;
	logic [71:0] bytes_q;
	logic [10:0] slot_q;
	job_t        job_q;
	logic        push;

	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [7:0]  bus_id_q;
	logic [7:0]  req_addr_q;
	logic [3:0]  req_length_q;
	logic [10:0] slot_out_q;
	logic [7:0]  value_q;
	logic [10:0] total_q;
	logic        last_q;

	assign push = active_q && (!out_valid_q || out_ready);
	assign busy = active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			rem_q       <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (job_load) begin
				active_q <= 1'b1;
				rem_q    <= job.nbytes;
			end else if (push) begin
				if (rem_q != 4'd0) begin
					rem_q <= rem_q - 4'd1;
				end else begin
					active_q <= 1'b0;
				end
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_load) begin
			bytes_q <= job.bytes;
			slot_q  <= job.base;
			job_q   <= job;
		end else if (push && rem_q != 4'd0) begin
			bytes_q <= {8'd0, bytes_q[71:8]};
			slot_q  <= slot_q + 11'd1;
		end

		if (push) begin
			kind_q       <= KIND_BYTE;
			bus_id_q     <= 8'd0;
			req_addr_q   <= 8'd0;
			req_length_q <= 4'd0;
			slot_out_q   <= 11'd0;
			value_q      <= 8'd0;
			total_q      <= 11'd0;
			last_q       <= 1'b0;
			if (rem_q != 4'd0) begin
				slot_out_q <= slot_q;
				value_q    <= bytes_q[7:0];
			end else if (job_q.fin_done) begin
				kind_q   <= KIND_DONE;
				bus_id_q <= job_q.requester;
				total_q  <= job_q.total;
				last_q   <= 1'b1;
			end else begin
				// The id memory was read when the item was taken; its output holds.
				kind_q       <= KIND_REQ;
				bus_id_q     <= mem_rdata;
				req_addr_q   <= job_q.addr;
				req_length_q <= job_q.len;
				last_q       <= 1'b1;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign bus_id     = bus_id_q;
	assign req_addr   = req_addr_q;
	assign req_length = req_length_q;
	assign slot       = slot_out_q;
	assign value      = value_q;
	assign total      = total_q;
	assign last       = last_q;

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		job_load |-> !active_q)
		else $error("new work loaded while results are still pending");

	a_byte_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q == KIND_BYTE) |-> !last_q)
		else $error("collected byte flagged as final result");

endmodule

// ----- src/sync_read_poll_sequencer.sv -----
// Group-read poller for a serial bus. Device ids are added to a list held in
// a synchronous memory; a start item then issues a read request to each id
// in turn, and every reply of the right size (or a timeout, counted in tick
// items) yields its bytes at slot index*(length+1), ending with a done result
// that carries the total size. An item that yields no result leaves the
// input ready, and the next may follow at once. An item that yields n results
// (n from 1 to 10) holds the input off while the single output register hands
// the results out one per cycle while out_ready stays high, and the next item
// can be taken once the last result has entered the output register.
// The id memory needs no clearing after reset. The configuration channel is
// always ready.
module sync_read_poll_sequencer #(
	parameter int MAX_IDS    = 128,
	parameter int MAX_LENGTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [7:0]  target_id,
	input  logic [7:0]  read_addr,
	input  logic [3:0]  read_length,
	input  logic [7:0]  reply_error,
	input  logic [7:0]  reply_count,
	input  logic [63:0] reply_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  bus_id,
	output logic [7:0]  req_addr,
	output logic [3:0]  req_length,
	output logic [10:0] slot,
	output logic [7:0]  value,
	output logic [10:0] total,
	output logic        last
);

	import srps_pkg::*;

	localparam int IDX_W = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;

	logic             in_accept;
	logic             emit_busy;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [7:0]       mem_wdata;
	logic             mem_re;
	logic [IDX_W-1:0] mem_raddr;
	logic [7:0]       mem_rdata;
	logic             job_load;
	job_t             job;

	assign cfg_ready = 1'b1;
	assign in_ready  = !emit_busy;
	assign in_accept = in_valid && in_ready;

	srps_id_mem #(
		.DEPTH (MAX_IDS),
		.IDX_W (IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	srps_ctrl #(
		.MAX_IDS    (MAX_IDS),
		.MAX_LENGTH (MAX_LENGTH),
		.IDX_W      (IDX_W)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_accept   (in_accept),
		.op          (op),
		.target_id   (target_id),
		.read_addr   (read_addr),
		.read_length (read_length),
		.reply_error (reply_error),
		.reply_count (reply_count),
		.reply_data  (reply_data),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_data    (cfg_data),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_re      (mem_re),
		.mem_raddr   (mem_raddr),
		.job_load    (job_load),
		.job         (job)
	);

	srps_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_load   (job_load),
		.job        (job),
		.mem_rdata  (mem_rdata),
		.busy       (emit_busy),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.bus_id     (bus_id),
		.req_addr   (req_addr),
		.req_length (req_length),
		.slot       (slot),
		.value      (value),
		.total      (total),
		.last       (last)
	);

endmodule
